// File: src/smfa_pkg.sv
// Shared constants, codes and types of the sign-magnitude fixed-point ALU.
package smfa_pkg;

   localparam int FRAC_BITS_DEFAULT = 5;
   localparam int MAG_W = 15;
   localparam int WORD_W = 16;
   localparam int PROD_W = 2 * MAG_W;

   localparam logic [3:0] KIND_ADD      = 4'd0;
   localparam logic [3:0] KIND_SUB      = 4'd1;
   localparam logic [3:0] KIND_MUL      = 4'd2;
   localparam logic [3:0] KIND_DIV      = 4'd3;
   localparam logic [3:0] KIND_NEG      = 4'd4;
   localparam logic [3:0] KIND_ABS      = 4'd5;
   localparam logic [3:0] KIND_COMPARE  = 4'd6;
   localparam logic [3:0] KIND_TO_INT   = 4'd7;
   localparam logic [3:0] KIND_FROM_INT = 4'd8;

   localparam logic [1:0] ORDER_LESS    = 2'b11;
   localparam logic [1:0] ORDER_EQUAL   = 2'b00;
   localparam logic [1:0] ORDER_GREATER = 2'b01;

   // Fields that ride alongside the divider stages.
   typedef struct packed {
      logic [3:0]        kind;
      logic              neg;
      logic [PROD_W-1:0] prod;
      logic [WORD_W-1:0] word;
      logic [10:0]       ires;
      logic [1:0]        order;
      logic              ovf;
   } side_type;

   // Attach the sign; a zero magnitude is always positive.
   function automatic logic [WORD_W-1:0] pack_word(input logic neg,
                                                   input logic [MAG_W-1:0] mag);
      pack_word = {neg && (mag != '0), mag};
   endfunction

endpackage

// File: src/smfa_if.sv
// Request and response channel interfaces of the sign-magnitude ALU.
interface smfa_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         kind;
   logic [15:0]        operand_a;
   logic [15:0]        operand_b;
   logic signed [15:0] int_value;

   modport source (output valid, kind, operand_a, operand_b, int_value, input ready);
   modport sink   (input valid, kind, operand_a, operand_b, int_value, output ready);
endinterface

interface smfa_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        result_word;
   logic signed [10:0] int_result;
   logic signed [1:0]  order;
   logic               overflow;
   logic               divide_by_zero;

   modport source (output valid, result_word, int_result, order, overflow, divide_by_zero,
                   input ready);
   modport sink   (input valid, result_word, int_result, order, overflow, divide_by_zero,
                   output ready);
endinterface

// File: src/smfa_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, side fields carried along.
module smfa_div_pipe
   import smfa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  side_type                  in_side,
   input  logic [MAG_W+FRAC_BITS-1:0] in_num,
   input  logic [MAG_W-1:0]          in_den,
   output logic                      out_valid,
   output side_type                  out_side,
   output logic [MAG_W+FRAC_BITS-1:0] out_quot,
   output logic                      out_den_zero
);
   localparam int DQ = MAG_W + FRAC_BITS;

   logic              valid_ff [DQ];
   side_type          side_ff  [DQ];
   logic [DQ-1:0]     num_ff   [DQ];
   logic [DQ-1:0]     quot_ff  [DQ];
   logic [MAG_W-1:0]  rem_ff   [DQ];
   logic [MAG_W-1:0]  den_ff   [DQ];

   logic [DQ-1:0]     num_in   [DQ];
   logic [DQ-1:0]     quot_in  [DQ];
   logic [MAG_W-1:0]  rem_in   [DQ];

   always_comb begin
      logic [DQ-1:0]    num_prev;
      logic [DQ-1:0]    quot_prev;
      logic [MAG_W-1:0] rem_prev;
      logic [MAG_W-1:0] den_cur;
      logic [MAG_W:0]   trial;
      for (int i = 0; i < DQ; i++) begin
         if (i == 0) begin
            num_prev  = in_num;
            quot_prev = '0;
            rem_prev  = '0;
            den_cur   = in_den;
         end else begin
            num_prev  = num_ff[i-1];
            quot_prev = quot_ff[i-1];
            rem_prev  = rem_ff[i-1];
            den_cur   = den_ff[i-1];
         end
         trial = {rem_prev, num_prev[DQ-1]};
         num_in[i] = num_prev << 1;
         if (trial >= {1'b0, den_cur}) begin
            rem_in[i]  = MAG_W'(trial - {1'b0, den_cur});
            quot_in[i] = {quot_prev[DQ-2:0], 1'b1};
         end else begin
            rem_in[i]  = trial[MAG_W-1:0];
            quot_in[i] = {quot_prev[DQ-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DQ; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DQ; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         den_ff[0]  <= in_den;
         for (int i = 1; i < DQ; i++) begin
            side_ff[i] <= side_ff[i-1];
            den_ff[i]  <= den_ff[i-1];
         end
         for (int i = 0; i < DQ; i++) begin
            num_ff[i]  <= num_in[i];
            quot_ff[i] <= quot_in[i];
            rem_ff[i]  <= rem_in[i];
         end
      end
   end

   assign out_valid    = valid_ff[DQ-1];
   assign out_side     = side_ff[DQ-1];
   assign out_quot     = quot_ff[DQ-1];
   assign out_den_zero = (den_ff[DQ-1] == '0);
endmodule

// File: src/sign_magnitude_fixed_point_alu.sv
// Pipeline from request to response: input register, one divider stage per quotient bit
// (15 + FRAC_BITS of them), output register.
// Throughput: one transaction per cycle; the whole pipeline holds while a response waits.
// Reset (synchronous, active high) clears all valid bits; payload registers are not reset.
module sign_magnitude_fixed_point_alu
   import smfa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   smfa_req_if.sink   req,
   smfa_rsp_if.source rsp
);
   localparam int DQ = MAG_W + FRAC_BITS;
   localparam int INT_BITS = MAG_W - FRAC_BITS;
   localparam logic [15:0] KEEP = 16'((32'd1 << INT_BITS) - 32'd1);

   logic advance;
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // Input register.
   logic        in_valid_ff;
   logic [3:0]  kind_ff;
   logic [15:0] a_ff, b_ff, iv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff <= req.kind;
         a_ff    <= req.operand_a;
         b_ff    <= req.operand_b;
         iv_ff   <= req.int_value;
      end
   end

   // Operate stage: everything except the divide and the scaling of the product.
   side_type          side_in;
   logic [MAG_W-1:0]  ma, mb;
   logic              sa, sb;
   logic signed [16:0] va, vb, sum;
   logic [16:0]       sum_mag;
   logic [MAG_W-1:0]  ip;
   logic [15:0]       iv_mag;
   logic [MAG_W-1:0]  fi_mag;

   always_comb begin
      ma = a_ff[MAG_W-1:0];
      mb = b_ff[MAG_W-1:0];
      sa = a_ff[15];
      sb = b_ff[15];
      va = sa ? -$signed({2'b00, ma}) : $signed({2'b00, ma});
      vb = sb ? -$signed({2'b00, mb}) : $signed({2'b00, mb});
      sum = (kind_ff == KIND_SUB) ? va - vb : va + vb;
      sum_mag = sum[16] ? 17'(-sum) : 17'(sum);
      ip = ma >> FRAC_BITS;
      iv_mag = iv_ff[15] ? 16'(-iv_ff) : iv_ff;
      fi_mag = MAG_W'(32'(iv_mag & KEEP) << FRAC_BITS);

      side_in.kind  = kind_ff;
      side_in.neg   = sa ^ sb;
      side_in.prod  = PROD_W'(ma) * PROD_W'(mb);
      side_in.word  = '0;
      side_in.ires  = '0;
      side_in.order = ORDER_EQUAL;
      side_in.ovf   = 1'b0;
      case (kind_ff)
         KIND_ADD, KIND_SUB: begin
            side_in.word = pack_word(sum[16], sum_mag[MAG_W-1:0]);
            side_in.ovf  = |sum_mag[16:MAG_W];
         end
         KIND_NEG: side_in.word = pack_word(!sa, ma);
         KIND_ABS: side_in.word = {1'b0, ma};
         KIND_COMPARE: begin
            if (va < vb) side_in.order = ORDER_LESS;
            else if (va > vb) side_in.order = ORDER_GREATER;
         end
         KIND_TO_INT: side_in.ires = sa ? 11'(-ip) : 11'(ip);
         KIND_FROM_INT: begin
            side_in.word = pack_word(iv_ff[15], fi_mag);
            side_in.ovf  = iv_mag > KEEP;
         end
         default: ;
      endcase
   end

   logic             dp_valid;
   side_type         dp_side;
   logic [DQ-1:0]    dp_quot;
   logic             dp_den_zero;

   smfa_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (in_valid_ff),
      .in_side      (side_in),
      .in_num       ({ma, {FRAC_BITS{1'b0}}}),
      .in_den       (mb),
      .out_valid    (dp_valid),
      .out_side     (dp_side),
      .out_quot     (dp_quot),
      .out_den_zero (dp_den_zero)
   );

   // Output stage: scale the product, finish the divide, pick the result.
   logic [PROD_W-1:0] prod_sh;
   logic [15:0]       word_in;
   logic              ovf_in, dz_in;

   always_comb begin
      prod_sh = dp_side.prod >> FRAC_BITS;
      word_in = dp_side.word;
      ovf_in  = dp_side.ovf;
      dz_in   = 1'b0;
      case (dp_side.kind)
         KIND_MUL: begin
            word_in = pack_word(dp_side.neg, prod_sh[MAG_W-1:0]);
            ovf_in  = |prod_sh[PROD_W-1:MAG_W];
         end
         KIND_DIV: begin
            if (dp_den_zero) begin
               word_in = '0;
               ovf_in  = 1'b0;
               dz_in   = 1'b1;
            end else begin
               word_in = pack_word(dp_side.neg, dp_quot[MAG_W-1:0]);
               ovf_in  = |dp_quot[DQ-1:MAG_W];
            end
         end
         default: ;
      endcase
   end

   logic        out_valid_ff;
   logic [15:0] word_ff;
   logic [10:0] ires_ff;
   logic [1:0]  order_ff;
   logic        ovf_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff  <= word_in;
         ires_ff  <= dp_side.ires;
         order_ff <= dp_side.order;
         ovf_ff   <= ovf_in;
         dz_ff    <= dz_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.result_word    = word_ff;
   assign rsp.int_result     = ires_ff;
   assign rsp.order          = order_ff;
   assign rsp.overflow       = ovf_ff;
   assign rsp.divide_by_zero = dz_ff;
endmodule

// File: src/smfa_checker.sv
// Port-level checks for the sign-magnitude ALU, bound to the top level.
module smfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_result_word,
   input logic        rsp_overflow,
   input logic        rsp_divide_by_zero
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_word))
      else $error("stalled response changed");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline stalled");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_result_word == 16'd0 && !rsp_overflow)
      else $error("divide by zero with nonzero result");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_word[14:0] == 15'd0 |-> !rsp_result_word[15])
      else $error("negative zero result");
endmodule

bind sign_magnitude_fixed_point_alu smfa_checker u_smfa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_result_word    (rsp.result_word),
   .rsp_overflow       (rsp.overflow),
   .rsp_divide_by_zero (rsp.divide_by_zero)
);

// File: tb/sv/sign_magnitude_fixed_point_alu_tb.sv
// Self-checking testbench of the sign-magnitude fixed-point ALU.
module sign_magnitude_fixed_point_alu_tb;
   import smfa_pkg::*;

   localparam int FB = FRAC_BITS_DEFAULT;
   localparam int LATENCY = 16 + FB;

   typedef struct packed {
      logic [3:0]         kind;
      logic [15:0]        operand_a;
      logic [15:0]        operand_b;
      logic signed [15:0] int_value;
   } alu_op_t;

   typedef struct packed {
      logic [15:0]        result_word;
      logic signed [10:0] int_result;
      logic signed [1:0]  order;
      logic               overflow;
      logic               divide_by_zero;
   } alu_res_t;

   // Directed row: known says whether the typed-in result is to be checked as well.
   typedef struct packed {
      alu_op_t  op;
      logic     known;
      alu_res_t res;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   smfa_req_if req ();
   smfa_rsp_if rsp ();

   sign_magnitude_fixed_point_alu dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   alu_res_t pending_results[$];
   int       errors = 0;
   int       checked = 0;
   int       sent = 0;
   int       send_idle_pct = 0;
   int       recv_stall_pct = 0;

   function automatic logic [15:0] attach_sign(input logic neg, input logic [31:0] mag,
                                               output logic ovf);
      logic [14:0] m;
      m = mag[14:0];
      ovf = (mag > 32'h7FFF);
      return {neg && (m != 0), m};
   endfunction

   function automatic int word_value(input logic [15:0] w);
      int m;
      m = int'(w[14:0]);
      return w[15] ? -m : m;
   endfunction

   function automatic alu_res_t alu_predict(input alu_op_t op);
      alu_res_t r;
      int sum;
      int ip;
      int va;
      int vb;
      logic [31:0] mag;
      logic [31:0] keep;
      logic neg;
      logic dummy;
      r = '0;
      case (op.kind)
         KIND_ADD, KIND_SUB: begin
            va = word_value(op.operand_a);
            vb = word_value(op.operand_b);
            sum = (op.kind == KIND_ADD) ? va + vb : va - vb;
            neg = sum < 0;
            mag = neg ? -sum : sum;
            r.result_word = attach_sign(neg, mag, r.overflow);
         end
         KIND_MUL: begin
            mag = (32'(op.operand_a[14:0]) * 32'(op.operand_b[14:0])) >> FB;
            r.result_word = attach_sign(op.operand_a[15] ^ op.operand_b[15], mag, r.overflow);
         end
         KIND_DIV: begin
            if (op.operand_b[14:0] == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               mag = (32'(op.operand_a[14:0]) << FB) / 32'(op.operand_b[14:0]);
               r.result_word = attach_sign(op.operand_a[15] ^ op.operand_b[15], mag,
                                           r.overflow);
            end
         end
         KIND_NEG: r.result_word = attach_sign(!op.operand_a[15], 32'(op.operand_a[14:0]),
                                               r.overflow);
         KIND_ABS: r.result_word = {1'b0, op.operand_a[14:0]};
         KIND_COMPARE: begin
            va = word_value(op.operand_a);
            vb = word_value(op.operand_b);
            r.order = (va < vb) ? ORDER_LESS : ((va > vb) ? ORDER_GREATER : ORDER_EQUAL);
         end
         KIND_TO_INT: begin
            ip = int'(op.operand_a[14:0] >> FB);
            if (op.operand_a[15]) ip = -ip;
            r.int_result = ip[10:0];
         end
         KIND_FROM_INT: begin
            neg = op.int_value[15];
            mag = neg ? 32'h10000 - 32'(op.int_value[15:0]) : 32'(op.int_value[15:0]);
            keep = (32'd1 << (15 - FB)) - 1;
            r.result_word = attach_sign(neg, (mag & keep) << FB, dummy);
            r.overflow = mag > keep;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, want);
   endtask

   // Compare every accepted response with the oldest outstanding prediction.
   always @(posedge clock) begin
      alu_res_t want;
      if (!reset && rsp.valid && rsp.ready) begin
         checked++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", rsp.result_word, 16'h0);
         end else begin
            want = pending_results.pop_front();
            if (rsp.result_word !== want.result_word)
               report_mismatch("result_word", rsp.result_word, want.result_word);
            if (rsp.int_result !== want.int_result)
               report_mismatch("int_result", 16'(rsp.int_result), 16'(want.int_result));
            if (rsp.order !== want.order)
               report_mismatch("order", 16'(rsp.order), 16'(want.order));
            if (rsp.overflow !== want.overflow)
               report_mismatch("overflow", 16'(rsp.overflow), 16'(want.overflow));
            if (rsp.divide_by_zero !== want.divide_by_zero)
               report_mismatch("divide_by_zero", 16'(rsp.divide_by_zero),
                               16'(want.divide_by_zero));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Present one transaction, with random idle cycles first, and hold until accepted.
   task automatic issue(input alu_op_t op);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.kind <= op.kind;
      req.operand_a <= op.operand_a;
      req.operand_b <= op.operand_b;
      req.int_value <= op.int_value;
      pending_results.push_back(alu_predict(op));
      sent++;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   function automatic logic [15:0] random_word();
      case ($urandom_range(5))
         0: return {1'($urandom), 15'h0};
         1: return {1'($urandom), 15'h7FFF};
         2: return {1'($urandom), 10'($urandom_range(3)), 5'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic alu_op_t random_op();
      alu_op_t op;
      op.kind = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      op.operand_a = random_word();
      op.operand_b = random_word();
      case ($urandom_range(3))
         0: op.int_value = 16'(16'($urandom_range(1023)) * ($urandom_range(1) ? 1 : -1));
         1: op.int_value = ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
         default: op.int_value = 16'($urandom);
      endcase
      return op;
   endfunction

   row_t directed[] = '{
      '{'{KIND_ADD, 16'h0000, 16'h0000, 16'sh0}, 1'b1, '{16'h0000, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_ADD, 16'h7FFF, 16'h0001, 16'sh0}, 1'b1, '{16'h0000, 11'sd0, 2'sd0, 1'b1, 1'b0}},
      '{'{KIND_ADD, 16'hFFFF, 16'h8001, 16'sh0}, 1'b1, '{16'h0000, 11'sd0, 2'sd0, 1'b1, 1'b0}},
      '{'{KIND_ADD, 16'h0020, 16'h8020, 16'sh0}, 1'b1, '{16'h0000, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_SUB, 16'h0020, 16'h8020, 16'sh0}, 1'b1, '{16'h0040, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_SUB, 16'h8000, 16'h0000, 16'sh0}, 1'b1, '{16'h0000, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_MUL, 16'h7FFF, 16'hFFFF, 16'sh0}, 1'b0, '0},
      '{'{KIND_MUL, 16'h0040, 16'h8060, 16'sh0}, 1'b1, '{16'h80C0, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_MUL, 16'h8001, 16'h0001, 16'sh0}, 1'b1, '{16'h0000, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_DIV, 16'h7FFF, 16'h8000, 16'sh0}, 1'b1, '{16'h0000, 11'sd0, 2'sd0, 1'b0, 1'b1}},
      '{'{KIND_DIV, 16'h7FFF, 16'h0001, 16'sh0}, 1'b0, '0},
      '{'{KIND_DIV, 16'h8040, 16'h0020, 16'sh0}, 1'b1, '{16'h8040, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_NEG, 16'h0000, 16'h0000, 16'sh0}, 1'b1, '{16'h0000, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_NEG, 16'h8000, 16'h0000, 16'sh0}, 1'b1, '{16'h0000, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_NEG, 16'h7FFF, 16'h0000, 16'sh0}, 1'b1, '{16'hFFFF, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_ABS, 16'hFFFF, 16'h0000, 16'sh0}, 1'b1, '{16'h7FFF, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_COMPARE, 16'h8000, 16'h0000, 16'sh0}, 1'b1, '{16'h0, 11'sd0, ORDER_EQUAL, 1'b0, 1'b0}},
      '{'{KIND_COMPARE, 16'h8010, 16'h8008, 16'sh0}, 1'b1, '{16'h0, 11'sd0, ORDER_LESS, 1'b0, 1'b0}},
      '{'{KIND_COMPARE, 16'h7FFF, 16'hFFFF, 16'sh0}, 1'b1,
        '{16'h0, 11'sd0, ORDER_GREATER, 1'b0, 1'b0}},
      '{'{KIND_TO_INT, 16'hFFFF, 16'h0000, 16'sh0}, 1'b1, '{16'h0, -11'sd1023, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_TO_INT, 16'h801F, 16'h0000, 16'sh0}, 1'b1, '{16'h0, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_FROM_INT, 16'h0, 16'h0, 16'sh8000}, 1'b1, '{16'h0000, 11'sd0, 2'sd0, 1'b1, 1'b0}},
      '{'{KIND_FROM_INT, 16'h0, 16'h0, -16'sd1023}, 1'b1, '{16'hFFE0, 11'sd0, 2'sd0, 1'b0, 1'b0}},
      '{'{KIND_FROM_INT, 16'h0, 16'h0, 16'sh7FFF}, 1'b0, '0},
      '{'{4'd15, 16'hFFFF, 16'hFFFF, -16'sd1}, 1'b1, '0}
   };

   initial begin
      alu_res_t table_res;
      req.valid <= 1'b0;
      req.kind <= '0;
      req.operand_a <= '0;
      req.operand_b <= '0;
      req.int_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         table_res = alu_predict(directed[i].op);
         if (directed[i].known && table_res !== directed[i].res)
            report_mismatch("directed row", 16'(i), 16'(i));
         issue(directed[i].op);
      end
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         repeat (500) issue(random_op());
      end
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      $display("sent %0d transactions, checked %0d responses, over four idle and stall mixes",
               sent, checked);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("timeout with %0d responses outstanding", pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
src/smfa_pkg.sv
src/smfa_if.sv
src/smfa_div_pipe.sv
src/sign_magnitude_fixed_point_alu.sv
src/smfa_checker.sv
tb/sv/sign_magnitude_fixed_point_alu_tb.sv
